FILE: hw/rtl/fpfa_pkg.sv
// shared types, constants and helpers of the fixed partition fit allocator
package fpfa_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    localparam int SIZE_W     = 16;
    localparam int TIME_W     = 16;
    localparam int WAIT_W     = 16;
    localparam int ELAPSED_W  = 32;
    localparam int BIDX_W     = 4;
    localparam int ACT_W      = 5;
    localparam int POL_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(16);

    // stream packing
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_PAD_W  = OUT_DATA_W - (BIDX_W + WAIT_W + ELAPSED_W);

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_TASK = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_NEXT  = 2'd1,
        POL_BEST  = 2'd2,
        POL_WORST = 2'd3
    } policy_t;

    typedef enum logic [1:0] {
        STAT_PLACED = 2'd0,
        STAT_REJECT = 2'd1,
        STAT_LOADED = 2'd2
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TICK,
        S_PLACE,
        S_SUM,
        S_CLEAR,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [BIDX_W-1:0] block_index;
        logic [SIZE_W-1:0] block_size;
        logic [SIZE_W-1:0] task_size;
        logic [TIME_W-1:0] task_duration;
        logic              last_task;
    } in_item_t;

    typedef struct packed {
        status_t              status;
        logic [BIDX_W-1:0]    placed_block;
        logic [WAIT_W-1:0]    wait_ticks;
        logic [ELAPSED_W-1:0] total_time;
        logic                 run_done;
    } result_t;

    // one partition as seen by the scan
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              busy;
        logic [TIME_W-1:0] left;
    } entry_t;

    // occupancy write port of the partition store
    typedef struct packed {
        logic             wr;
        logic [IDX_W-1:0] addr;
        logic             busy;
        logic [TIME_W-1:0] left;
        logic             clear;
    } slot_wr_t;

    // size write port of the partition store
    typedef struct packed {
        logic              wr;
        logic [IDX_W-1:0]  addr;
        logic [SIZE_W-1:0] size;
    } size_wr_t;

    // what the shared unit says about one entry
    typedef struct packed {
        logic                 fit;
        logic                 free_fit;
        logic                 take;
        logic [TIME_W-1:0]    tval;
        logic                 k_less;
        logic [TIME_W-1:0]    left_after;
        logic                 busy_after;
        logic [ELAPSED_W-1:0] sum;
    } unit_res_t;

    // index of the last partition in use, count clamped to 1..NUM_BLOCKS
    function automatic logic [IDX_W-1:0] last_index(input logic [ACT_W-1:0] active);
        int a;
        a = int'(active);
        if (a < 1) a = 1;
        if (a > NUM_BLOCKS) a = NUM_BLOCKS;
        return IDX_W'(a - 1);
    endfunction

endpackage

FILE: hw/rtl/fixed_partition_fit_allocator_core.sv
// top level of the fixed partition fit allocator
//
// s_ channel takes one item at a time: a size load (s_tuser low) or a task
// (s_tuser high, s_tlast marks the last task of a run). m_ channel returns
// exactly one result item per input item, in order. cfg_ writes fit_policy
// (index 0) and active_blocks (index 1); write only while the block is idle.
// a load writes its size when accepted. a task scans the n active partitions
// one per cycle through a single shared compare/subtract/add unit: a free
// partition that fits is placed after one scan; a task that has to wait for
// a release takes one scan, one tick pass over the busy times and one rescan
// before placement. the last task of a run adds a run total sum and a clear.
// s_tready is low while an item is in work; a finished result waits in the
// output register, so the next item is accepted while m_tready is low, and
// the sequencer holds its following result until that register frees.
// aresetn (synchronous, active low) clears the policy to first fit, the
// active count to 16, occupancy, elapsed time and rover; sizes stay unknown
// until loaded.
module fixed_partition_fit_allocator_core import fpfa_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // block_index, block_size, task_size, task_duration
    input  logic                  s_tuser,   // operation
    input  logic                  s_tlast,   // last_task
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // placed_block, wait_ticks, total_time
    output logic [1:0]            m_tuser,   // status
    output logic                  m_tlast,   // run_done
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    policy_t          policy_reg;
    logic [ACT_W-1:0] active_reg;

    logic             m_tvalid_reg, m_tvalid_next;
    result_t          out_reg, out_next;

    in_item_t         in_item;
    result_t          res;
    logic             res_valid;
    logic             res_ready;

    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_entry;
    slot_wr_t         slot_wr;
    size_wr_t         size_wr;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= POL_FIRST;
            active_reg <= ACT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_POLICY: policy_reg <= policy_t'(cfg_data[POL_W-1:0]);
                CFG_ACTIVE: active_reg <= cfg_data[ACT_W-1:0];
                default: ;
            endcase
        end
    end

    // unpack the input item, first field in the low bits
    assign in_item.op            = op_t'(s_tuser);
    assign in_item.block_index   = s_tdata[BIDX_W-1:0];
    assign in_item.block_size    = s_tdata[BIDX_W +: SIZE_W];
    assign in_item.task_size     = s_tdata[BIDX_W+SIZE_W +: SIZE_W];
    assign in_item.task_duration = s_tdata[BIDX_W+2*SIZE_W +: TIME_W];
    assign in_item.last_task     = s_tlast;

    fpfa_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .slot_wr  (slot_wr),
        .size_wr  (size_wr)
    );

    fpfa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .policy    (policy_reg),
        .active    (active_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_addr   (rd_addr),
        .rd_entry  (rd_entry),
        .slot_wr   (slot_wr),
        .size_wr   (size_wr)
    );

    // output register: takes a result when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_reg.total_time, out_reg.wait_ticks,
                       out_reg.placed_block};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.run_done;

`ifndef ASSERT_OFF
    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // a rejected task carries no partition and no wait
    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_REJECT |-> m_tdata[BIDX_W+WAIT_W-1:0] == '0)
        else $error("rejected task reports a placement");

    // the run total only shows on the last task
    a_total_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[BIDX_W+WAIT_W +: ELAPSED_W] == '0)
        else $error("run total outside run end");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule

FILE: hw/rtl/fpfa_store.sv
// partition store: sizes, busy flags and remaining times
module fpfa_store import fpfa_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_entry,
    input  slot_wr_t         slot_wr,
    input  size_wr_t         size_wr
);

    logic [SIZE_W-1:0] size_reg [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] busy_reg;
    logic [TIME_W-1:0] left_reg [NUM_BLOCKS];

    // sizes stay undefined until loaded
    always_ff @(posedge aclk) begin
        if (size_wr.wr) begin
            size_reg[size_wr.addr] <= size_wr.size;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || slot_wr.clear) begin
            busy_reg <= '0;
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                left_reg[i] <= '0;
            end
        end else if (slot_wr.wr) begin
            busy_reg[slot_wr.addr] <= slot_wr.busy;
            left_reg[slot_wr.addr] <= slot_wr.left;
        end
    end

    assign rd_entry.size = size_reg[rd_addr];
    assign rd_entry.busy = busy_reg[rd_addr];
    assign rd_entry.left = left_reg[rd_addr];

endmodule

FILE: hw/rtl/fpfa_unit.sv
// shared compare / subtract / add unit applied to one partition per cycle
module fpfa_unit import fpfa_pkg::*; (
    input  entry_t               entry,
    input  logic [SIZE_W-1:0]    task_size,
    input  policy_t              policy,
    input  logic                 pick_valid,
    input  logic [SIZE_W-1:0]    pick_size,
    input  logic [TIME_W-1:0]    k,
    input  logic [ELAPSED_W-1:0] acc,
    output unit_res_t            res
);

    logic                 fit;
    logic                 better;
    logic                 over;
    logic [ELAPSED_W:0]   sum;

    always_comb begin
        fit = task_size <= entry.size;
        case (policy)
            POL_BEST:  better = pick_size >= entry.size;
            POL_WORST: better = pick_size <= entry.size;
            default:   better = 1'b0;
        endcase

        res.fit      = fit;
        res.free_fit = fit & ~entry.busy;
        res.take     = fit & ~entry.busy & (~pick_valid | better);

        // zero time left still costs one tick
        res.tval   = (entry.left == '0) ? TIME_W'(1) : entry.left;
        res.k_less = res.tval < k;

        over           = entry.left > k;
        res.busy_after = entry.busy & over;
        if (!entry.busy) begin
            res.left_after = entry.left;
        end else if (over) begin
            res.left_after = entry.left - k;
        end else begin
            res.left_after = '0;
        end

        sum     = {1'b0, acc} + (ELAPSED_W+1)'(entry.busy ? entry.left : TIME_W'(0));
        res.sum = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
    end

endmodule

FILE: hw/rtl/fpfa_ctrl.sv
// sequencer: scan, tick, place, sum and clear passes over the partitions
module fpfa_ctrl import fpfa_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_item,
    input  policy_t          policy,
    input  logic [ACT_W-1:0] active,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res,
    output logic [IDX_W-1:0] rd_addr,
    input  entry_t           rd_entry,
    output slot_wr_t         slot_wr,
    output size_wr_t         size_wr
);

    state_t state_reg, state_next;

    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [TIME_W-1:0]    dur_reg, dur_next;
    logic                 last_reg, last_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 fits_reg, fits_next;
    logic                 pv_reg, pv_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_W-1:0]    psize_reg, psize_next;
    logic                 av_reg, av_next;
    logic [IDX_W-1:0]     after_reg, after_next;
    logic [TIME_W-1:0]    k_reg, k_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [IDX_W-1:0]     rover_reg, rover_next;
    logic [WAIT_W-1:0]    wait_reg, wait_next;
    logic [ELAPSED_W-1:0] total_reg, total_next;
    status_t              status_reg, status_next;
    logic [BIDX_W-1:0]    placed_reg, placed_next;

    unit_res_t            u;
    logic [IDX_W-1:0]     n_last;
    logic [IDX_W-1:0]     start;
    logic [IDX_W-1:0]     choice;
    logic                 scan_end;
    logic                 fits_step;
    logic                 pv_step;
    logic [TIME_W-1:0]    k_step;
    logic [ELAPSED_W:0]   el_sum;

    fpfa_unit u_unit (
        .entry      (rd_entry),
        .task_size  (size_reg),
        .policy     (policy),
        .pick_valid (pv_reg),
        .pick_size  (psize_reg),
        .k          (k_reg),
        .acc        (total_reg),
        .res        (u)
    );

    assign n_last   = last_index(active);
    assign start    = (rover_reg <= n_last) ? rover_reg : '0;
    assign choice   = (policy == POL_NEXT && av_reg) ? after_reg : pick_reg;
    assign scan_end = idx_reg == n_last;
    assign rd_addr  = idx_reg;

    assign fits_step = fits_reg | u.fit;
    assign pv_step   = pv_reg | u.take;
    assign k_step    = (u.fit && u.k_less) ? u.tval : k_reg;
    assign el_sum    = {1'b0, elapsed_reg} + (ELAPSED_W+1)'(k_step);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next = (in_item.op == OP_LOAD) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    if (!fits_step) begin
                        state_next = last_reg ? S_SUM : S_DONE;
                    end else if (pv_step) begin
                        state_next = S_PLACE;
                    end else begin
                        state_next = S_TICK;
                    end
                end
            end
            S_TICK: begin
                if (scan_end) begin
                    state_next = S_SCAN;
                end
            end
            S_PLACE: state_next = last_reg ? S_SUM : S_DONE;
            S_SUM: begin
                if (scan_end) begin
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR: state_next = S_DONE;
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready  = state_reg == S_IDLE;
        res_valid = state_reg == S_DONE;

        slot_wr       = '0;
        slot_wr.addr  = idx_reg;
        slot_wr.busy  = u.busy_after;
        slot_wr.left  = u.left_after;
        size_wr.wr    = 1'b0;
        size_wr.addr  = IDX_W'(in_item.block_index);
        size_wr.size  = in_item.block_size;

        case (state_reg)
            S_IDLE: begin
                size_wr.wr = in_valid && in_item.op == OP_LOAD
                             && int'(in_item.block_index) < NUM_BLOCKS;
            end
            S_TICK: slot_wr.wr = 1'b1;
            S_PLACE: begin
                slot_wr.wr   = 1'b1;
                slot_wr.addr = choice;
                slot_wr.busy = 1'b1;
                slot_wr.left = dur_reg;
            end
            S_CLEAR: slot_wr.clear = 1'b1;
            default: ;
        endcase

        res.status       = status_reg;
        res.placed_block = placed_reg;
        res.wait_ticks   = wait_reg;
        res.total_time   = last_reg ? total_reg : '0;
        res.run_done     = last_reg;
    end

    // datapath
    always_comb begin
        size_next    = size_reg;
        dur_next     = dur_reg;
        last_next    = last_reg;
        idx_next     = idx_reg;
        fits_next    = fits_reg;
        pv_next      = pv_reg;
        pick_next    = pick_reg;
        psize_next   = psize_reg;
        av_next      = av_reg;
        after_next   = after_reg;
        k_next       = k_reg;
        elapsed_next = elapsed_reg;
        rover_next   = rover_reg;
        wait_next    = wait_reg;
        total_next   = total_reg;
        status_next  = status_reg;
        placed_next  = placed_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    size_next   = in_item.task_size;
                    dur_next    = in_item.task_duration;
                    last_next   = (in_item.op == OP_TASK) && in_item.last_task;
                    status_next = (in_item.op == OP_LOAD) ? STAT_LOADED : STAT_PLACED;
                    idx_next    = '0;
                    fits_next   = 1'b0;
                    pv_next     = 1'b0;
                    av_next     = 1'b0;
                    k_next      = '1;
                    wait_next   = '0;
                    placed_next = '0;
                    total_next  = '0;
                end
            end
            S_SCAN: begin
                fits_next = fits_step;
                k_next    = k_step;
                if (u.take) begin
                    pv_next    = 1'b1;
                    pick_next  = idx_reg;
                    psize_next = rd_entry.size;
                end
                if (policy == POL_NEXT && u.free_fit && !av_reg && idx_reg >= start) begin
                    av_next    = 1'b1;
                    after_next = idx_reg;
                end
                if (scan_end) begin
                    idx_next   = '0;
                    total_next = elapsed_reg;
                    if (!fits_step) begin
                        status_next = STAT_REJECT;
                    end else if (!pv_step) begin
                        // every fitting partition busy: jump to the first release
                        wait_next    = WAIT_W'(k_step);
                        elapsed_next = el_sum[ELAPSED_W] ? '1 : el_sum[ELAPSED_W-1:0];
                    end
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_TICK: begin
                if (scan_end) begin
                    idx_next  = '0;
                    fits_next = 1'b0;
                    pv_next   = 1'b0;
                    av_next   = 1'b0;
                    k_next    = '1;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_PLACE: begin
                placed_next = BIDX_W'(choice);
                total_next  = elapsed_reg;
                idx_next    = '0;
                if (policy == POL_NEXT) begin
                    rover_next = (choice == n_last) ? '0 : choice + IDX_W'(1);
                end
            end
            S_SUM: begin
                total_next = u.sum;
                idx_next   = scan_end ? '0 : idx_reg + IDX_W'(1);
            end
            S_CLEAR: begin
                elapsed_next = '0;
                rover_next   = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            elapsed_reg <= '0;
            rover_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            rover_reg   <= rover_next;
        end
    end

    always_ff @(posedge aclk) begin
        size_reg   <= size_next;
        dur_reg    <= dur_next;
        last_reg   <= last_next;
        idx_reg    <= idx_next;
        fits_reg   <= fits_next;
        pv_reg     <= pv_next;
        pick_reg   <= pick_next;
        psize_reg  <= psize_next;
        av_reg     <= av_next;
        after_reg  <= after_next;
        k_reg      <= k_next;
        wait_reg   <= wait_next;
        total_reg  <= total_next;
        status_reg <= status_next;
        placed_reg <= placed_next;
    end

endmodule

FILE: sim/tb.sv
// self-checking testbench for the fixed partition fit allocator core
module tb;
    import fpfa_pkg::*;

    localparam int HOLD_LEN    = 400;   // long output hold-off, in cycles
    localparam int TAIL_CYCLES = 80;    // margin over the worst task plus run sum and clear
    localparam int QUIET_LIMIT = 3000;  // cycles with no handshake before giving up
    localparam int PHASE_ITEMS = 580;   // random items per idle mode, three modes
    localparam int SETTINGS_N  = 12;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    fixed_partition_fit_allocator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // allocator state as the checker sees it
    logic [SIZE_W-1:0]    part_size [NUM_BLOCKS];
    bit                   part_busy [NUM_BLOCKS];
    logic [TIME_W-1:0]    part_left [NUM_BLOCKS];
    int unsigned          rover_pos;
    logic [ELAPSED_W-1:0] elapsed_ticks;
    policy_t              cfg_policy;
    logic [ACT_W-1:0]     cfg_active;

    result_t     pending_results [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int          setting_no = 0;
    result_t     got, want;

    policy_t     policy_tab [SETTINGS_N] = '{POL_NEXT, POL_NEXT, POL_FIRST, POL_BEST,
                                             POL_WORST, POL_NEXT, POL_BEST, POL_WORST,
                                             POL_FIRST, POL_NEXT, POL_BEST, POL_WORST};
    // 0 and 31 exercise the clamp of the active count
    int          active_tab [SETTINGS_N] = '{16, 3, 0, 31, 1, 16, 16, 8, 2, 5, 15, 16};

    function automatic void clear_run();
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            part_busy[i] = 1'b0;
            part_left[i] = '0;
        end
        rover_pos     = 0;
        elapsed_ticks = '0;
    endfunction

    function automatic void reset_state();
        for (int i = 0; i < NUM_BLOCKS; i++) part_size[i] = '0;
        cfg_policy = POL_FIRST;
        cfg_active = ACT_RESET;
        clear_run();
    endfunction

    function automatic int unsigned blocks_in_use();
        int unsigned n;
        n = cfg_active;
        if (n < 1) n = 1;
        if (n > NUM_BLOCKS) n = NUM_BLOCKS;
        return n;
    endfunction

    // free partition chosen by the current policy, -1 if none fits
    function automatic int choose_partition(int unsigned n, int unsigned need);
        int          pick;
        int unsigned j;
        pick = -1;
        if (cfg_policy == POL_NEXT) begin
            j = (rover_pos < n) ? rover_pos : 0;
            for (int i = 0; i < n; i++) begin
                if (!part_busy[j] && need <= part_size[j]) return j;
                j = (j + 1 == n) ? 0 : j + 1;
            end
            return -1;
        end
        for (int i = 0; i < n; i++) begin
            if (part_busy[i] || need > part_size[i]) continue;
            if (cfg_policy == POL_FIRST) return i;
            if (pick < 0) pick = i;
            else if (cfg_policy == POL_BEST && part_size[pick] >= part_size[i]) pick = i;
            else if (cfg_policy == POL_WORST && part_size[pick] <= part_size[i]) pick = i;
        end
        return pick;
    endfunction

    // advance the run clock by k ticks at once
    function automatic void pass_ticks(int unsigned n, int unsigned k);
        longint unsigned tally;
        tally = longint'(elapsed_ticks) + k;
        elapsed_ticks = (tally > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tally[31:0];
        for (int i = 0; i < n; i++) begin
            if (!part_busy[i]) continue;
            if (part_left[i] > k) begin
                part_left[i] = TIME_W'(part_left[i] - k);
            end else begin
                part_left[i] = '0;
                part_busy[i] = 1'b0;
            end
        end
    endfunction

    // apply one item to the allocator state and return its result
    function automatic result_t allocate(input in_item_t it);
        result_t         r;
        int unsigned     n, k, t, ticks;
        int              pick;
        bit              fits;
        longint unsigned tally;
        r = '0;
        if (it.op == OP_LOAD) begin
            part_size[it.block_index] = it.block_size;
            r.status = STAT_LOADED;
            return r;
        end
        n     = blocks_in_use();
        fits  = 1'b0;
        ticks = 0;
        for (int i = 0; i < n; i++)
            if (it.task_size <= part_size[i]) fits = 1'b1;
        if (!fits) begin
            r.status = STAT_REJECT;
        end else begin
            pick = choose_partition(n, it.task_size);
            if (pick < 0) begin
                // every fitting partition is busy: wait for the first to free
                k = 32'hFFFF_FFFF;
                for (int i = 0; i < n; i++) begin
                    if (it.task_size <= part_size[i]) begin
                        t = (part_left[i] != 0) ? part_left[i] : 1;
                        if (t < k) k = t;
                    end
                end
                pass_ticks(n, k);
                ticks = k;
                pick  = choose_partition(n, it.task_size);
            end
            if (pick < 0) pick = 0;
            part_busy[pick] = 1'b1;
            part_left[pick] = it.task_duration;
            if (cfg_policy == POL_NEXT) rover_pos = (pick + 1 == n) ? 0 : pick + 1;
            r.status       = STAT_PLACED;
            r.placed_block = pick[BIDX_W-1:0];
            r.wait_ticks   = (ticks > 16'hFFFF) ? 16'hFFFF : ticks[WAIT_W-1:0];
        end
        if (it.last_task) begin
            tally = elapsed_ticks;
            for (int i = 0; i < n; i++)
                if (part_busy[i]) tally += part_left[i];
            r.total_time = (tally > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tally[31:0];
            r.run_done   = 1'b1;
            clear_run();
        end
        return r;
    endfunction

    function automatic in_item_t make_item(op_t op, int unsigned idx, int unsigned bsize,
                                           int unsigned tsize, int unsigned dur, bit last);
        in_item_t it;
        it.op            = op;
        it.block_index   = idx[BIDX_W-1:0];
        it.block_size    = bsize[SIZE_W-1:0];
        it.task_size     = tsize[SIZE_W-1:0];
        it.task_duration = dur[TIME_W-1:0];
        it.last_task     = last;
        return it;
    endfunction

    // mostly tasks sized around the loaded partitions, some loads and noise
    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned n, sel, base;
        n                = blocks_in_use();
        it.block_index   = BIDX_W'($urandom);
        it.block_size    = SIZE_W'($urandom);
        it.task_size     = SIZE_W'($urandom);
        it.task_duration = TIME_W'($urandom);
        it.last_task     = ($urandom_range(24) == 0);
        if ($urandom_range(9) == 0) begin
            it.op = OP_LOAD;
            sel   = $urandom_range(99);
            if (sel < 40)      it.block_size = SIZE_W'(64 * $urandom_range(1, 16));  // ties
            else if (sel < 85) it.block_size = SIZE_W'($urandom);
            else if (sel < 93) it.block_size = '0;
            else               it.block_size = '1;
            return it;
        end
        it.op = OP_TASK;
        base  = part_size[$urandom_range(n - 1)];
        sel   = $urandom_range(99);
        if (sel < 40)      it.task_size = SIZE_W'((base > 3) ? base - $urandom_range(3) : base);
        else if (sel < 55) it.task_size = SIZE_W'((base < 16'hFFFF) ? base + 1 : base);
        else if (sel < 75) it.task_size = SIZE_W'($urandom_range(200));
        else if (sel < 92) it.task_size = SIZE_W'($urandom);
        else if (sel < 96) it.task_size = '0;
        else               it.task_size = '1;
        sel = $urandom_range(99);
        if (sel < 70)      it.task_duration = TIME_W'($urandom_range(1, 12));
        else if (sel < 85) it.task_duration = TIME_W'($urandom_range(13, 500));
        else if (sel < 96) it.task_duration = TIME_W'($urandom);
        else               it.task_duration = '0;
        return it;
    endfunction

    // send one item; valid stays high into the next call when no gap is drawn
    task automatic send_item(input in_item_t it);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {4'd0, it.task_duration, it.task_size, it.block_size, it.block_index};
        s_tuser  = it.op;
        s_tlast  = it.last_task;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(allocate(it));
    endtask

    // stop sending and let every outstanding result come back
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_POLICY) cfg_policy = policy_t'(val[POL_W-1:0]);
        else                   cfg_active = val;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic log_failure(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    // load every partition so no task ever reads an unwritten size
    task automatic test_size_loading();
        int unsigned sizes [NUM_BLOCKS] = '{0, 1, 100, 100, 500, 1000, 65534, 2000,
                                            100, 30000, 7, 999, 4096, 32768, 12345, 250};
        for (int i = 0; i < NUM_BLOCKS; i++)
            send_item(make_item(OP_LOAD, i, sizes[i], 16'hFFFF, 0, 1'b0));
    endtask

    task automatic test_special_cases();
        // too big for every partition, and it closes the run anyway
        send_item(make_item(OP_TASK, 15, 16'hFFFF, 16'hFFFF, 5, 1'b1));
        // zero-size task into a zero-size partition, with zero duration
        send_item(make_item(OP_TASK, 0, 0, 0, 0, 1'b0));
        send_item(make_item(OP_TASK, 0, 0, 0, 16'hFFFF, 1'b0));
        // resize a busy partition mid-run
        send_item(make_item(OP_LOAD, 0, 16'hFFFF, 0, 0, 1'b0));
        // only the busy zero-time partition fits: one tick frees it
        send_item(make_item(OP_TASK, 0, 0, 16'hFFFF, 16'hFFFF, 1'b0));
        // longest possible wait
        send_item(make_item(OP_TASK, 0, 0, 16'hFFFF, 3, 1'b0));
        send_item(make_item(OP_TASK, 0, 0, 1, 1, 1'b1));
        settle();
    endtask

    // random traffic over four register settings per idle mode
    task automatic test_policy_sweep(input int tx_pct, input int rx_pct);
        int idx;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int s = 0; s < 4; s++) begin
            settle();
            idx = setting_no % SETTINGS_N;
            setting_no++;
            write_reg(CFG_POLICY, {3'($urandom_range(7)), policy_tab[idx]});
            write_reg(CFG_ACTIVE, CFG_DATA_W'(active_tab[idx]));
            repeat (PHASE_ITEMS / 4) send_item(random_item());
        end
        settle();
    endtask

    // receiver holds off while items keep coming, then the sender pauses
    task automatic test_output_stall();
        tx_idle_pct = 0;
        hold_requests++;
        repeat (30) send_item(random_item());
        settle();
    endtask

    initial begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        aresetn   = 1'b0;
        reset_state();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_size_loading();
        test_special_cases();
        test_policy_sweep(9, 75);
        test_output_stall();
        test_policy_sweep(75, 9);
        test_policy_sweep(0, 0);
        test_output_stall();

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // output ready: long hold when asked, else random idling
    always @(negedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // compare each result item with the oldest pending prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.status       = status_t'(m_tuser);
            got.placed_block = m_tdata[3:0];
            got.wait_ticks   = m_tdata[19:4];
            got.total_time   = m_tdata[51:20];
            got.run_done     = m_tlast;
            if (pending_results.size() == 0) begin
                log_failure($sformatf("result %0d arrived with nothing pending", results_seen));
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.placed_block !== want.placed_block ||
                    got.wait_ticks !== want.wait_ticks || got.total_time !== want.total_time ||
                    got.run_done !== want.run_done)
                    log_failure($sformatf({"result %0d: expected status %0d block %0d ",
                        "wait %0d total %0d done %0d, got status %0d block %0d wait %0d ",
                        "total %0d done %0d"}, results_seen, want.status, want.placed_block,
                        want.wait_ticks, want.total_time, want.run_done, got.status,
                        got.placed_block, got.wait_ticks, got.total_time, got.run_done));
            end
            results_seen++;
        end
    end

    // watchdog on stretches with no handshake anywhere
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

FILE: filelist.f
hw/rtl/fpfa_pkg.sv
hw/rtl/fpfa_store.sv
hw/rtl/fpfa_unit.sv
hw/rtl/fpfa_ctrl.sv
hw/rtl/fixed_partition_fit_allocator_core.sv
sim/tb.sv
